// ===== rtl/core/pts_pkg.sv =====
// Shared constants, types and codes for the priority task slot scheduler.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package pts_pkg;

  // Table and stack sizes.
  localparam int SLOTS      = 64;
  localparam int NEST_DEPTH = 8;

  // Derived index and count widths.
  localparam int SLOT_IW = $clog2(SLOTS);
  localparam int NEST_IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int NEST_CW = $clog2(NEST_DEPTH + 1);

  // Field widths.
  localparam int HANDLE_W   = 16;
  localparam int ARG_W      = 32;
  localparam int PRIO_W     = 8;
  localparam int LEVEL_W    = 9;
  localparam int OUT_SLOT_W = 6;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;

  // Stream widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  // Item kinds carried in the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD      = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_FINISH   = 2'd2
  } kind_t;

  // Result status codes carried in the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_FULL        = 3'd1,
    ST_DISPATCHED  = 3'd2,
    ST_NONE        = 3'd3,
    ST_FINISHED    = 3'd4,
    ST_IDLE_FINISH = 3'd5,
    ST_NEST_FULL   = 3'd6
  } status_t;

  // One stored task.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    arg;
    logic [PRIO_W-1:0]   level;
  } slot_data_t;

  // Write-side controls of the slot memory.
  typedef struct packed {
    logic               wr_en;   // store data and mark the slot busy
    logic               clr_en;  // mark the slot free
    logic [SLOT_IW-1:0] idx;
    slot_data_t         data;
  } slot_wr_t;

  // Controls of the nesting stack.
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [LEVEL_W-1:0] push_level;  // new running level on push
  } nest_ctrl_t;

endpackage

// ===== rtl/core/priority_task_slot_scheduler.sv =====
// Top level of the priority task slot scheduler: sequencer, scan and result register.
// Depends on pts_pkg, pts_slot_mem and pts_nest_stack.
`timescale 1ns / 1ps

// Usage
// The input stream carries one transaction per scheduler event: in_tuser holds the
// kind (add, dispatch, finish) and in_tdata the task handle, argument and priority.
// Kind code 3 is accepted and dropped without a result. Every other transaction
// gives exactly one result transaction: out_tuser holds the status and out_tdata
// the handle, argument, priority, slot and running level after the event.
// Add and dispatch scan the whole slot memory, one entry per cycle through its single
// read port; an add or dispatch passes from acceptance through the scan, drain and
// commit steps into the output register. A finish touches only the nesting stack and
// goes from acceptance straight to its commit step. in_tready is high only between
// events, so a new event is taken only after the last one has committed.
// The result sits in an output register: while the receiver stalls, the next event
// is still accepted and worked on, and it waits only at its commit step until the
// held result is taken.
// After reset every slot is free, the nesting stack is empty and the running level
// is minus one (idle); no clearing pass is needed.

module priority_task_slot_scheduler
  import pts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] task_handle, [47:16] task_arg, [55:48] task_priority
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] out_handle, [47:16] out_arg, [55:48] out_priority, [61:56] out_slot,
  // [70:62] running_level, [71] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]    out_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Latched item.
  kind_t               kind_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [ARG_W-1:0]    arg_r;
  logic [PRIO_W-1:0]   prio_r;

  // Scan address and the registered read stage that trails it.
  logic [SLOT_IW-1:0] scan_idx_r;
  logic               rd_vld_r;
  logic [SLOT_IW-1:0] rd_idx_r;
  slot_data_t         rd_data;
  logic               rd_busy;

  // Scan results.
  logic               free_found_r;
  logic [SLOT_IW-1:0] free_idx_r;
  logic               best_found_r;
  logic [SLOT_IW-1:0] best_idx_r;
  slot_data_t         best_r;

  // Output register.
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]    out_tuser_r;

  slot_wr_t                  slot_wr;
  nest_ctrl_t                nest_ctrl;
  logic signed [LEVEL_W-1:0] running;
  logic signed [LEVEL_W-1:0] nest_top;
  logic                      nest_empty;
  logic                      nest_full;

  logic                      in_fire;
  logic                      commit;
  logic                      eligible;
  status_t                   res_status;
  logic [HANDLE_W-1:0]       res_handle;
  logic [ARG_W-1:0]          res_arg;
  logic [PRIO_W-1:0]         res_prio;
  logic [SLOT_IW-1:0]        res_slot;
  logic signed [LEVEL_W-1:0] res_level;

  pts_slot_mem u_slot_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx_i  (scan_idx_r),
    .rd_data_o (rd_data),
    .rd_busy_o (rd_busy),
    .wr_i      (slot_wr)
  );

  pts_nest_stack u_nest_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_i    (nest_ctrl),
    .running_o (running),
    .top_o     (nest_top),
    .empty_o   (nest_empty),
    .full_o    (nest_full)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign commit     = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The best task may run only above the current running level.
  assign eligible = best_found_r && ($signed({1'b0, best_r.level}) > running);

  // Result of the event and the state updates it makes at commit.
  always_comb begin
    res_status = ST_NONE;
    res_handle = '0;
    res_arg    = '0;
    res_prio   = '0;
    res_slot   = '0;
    res_level  = running;
    slot_wr    = '0;
    nest_ctrl  = '0;
    case (kind_r)
      KIND_ADD: begin
        if (free_found_r) begin
          res_status   = ST_ADDED;
          res_slot     = free_idx_r;
          slot_wr.wr_en       = commit;
          slot_wr.idx         = free_idx_r;
          slot_wr.data.handle = handle_r;
          slot_wr.data.arg    = arg_r;
          slot_wr.data.level  = prio_r;
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_DISPATCH: begin
        if (!eligible) begin
          res_status = ST_NONE;
        end else if (nest_full) begin
          res_status = ST_NEST_FULL;
        end else begin
          res_status = ST_DISPATCHED;
          res_handle = best_r.handle;
          res_arg    = best_r.arg;
          res_prio   = best_r.level;
          res_slot   = best_idx_r;
          res_level  = $signed({1'b0, best_r.level});
          slot_wr.clr_en       = commit;
          slot_wr.idx          = best_idx_r;
          nest_ctrl.push       = commit;
          nest_ctrl.push_level = $signed({1'b0, best_r.level});
        end
      end
      KIND_FINISH: begin
        if (nest_empty) begin
          res_status = ST_IDLE_FINISH;
        end else begin
          res_status    = ST_FINISHED;
          res_level     = nest_top;
          nest_ctrl.pop = commit;
        end
      end
      default: begin
        res_status = ST_NONE;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (kind_t'(in_tuser) == KIND_ADD || kind_t'(in_tuser) == KIND_DISPATCH) begin
            state_nxt = S_SCAN;
          end else if (kind_t'(in_tuser) == KIND_FINISH) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_r == SLOT_IW'(SLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, read-stage control and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SCAN);
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_tuser_r <= res_status;
      out_tdata_r <= {1'b0, res_level, OUT_SLOT_W'(res_slot), res_prio, res_arg, res_handle};
    end
  end

  // Item latch and scan address.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r     <= kind_t'(in_tuser);
      handle_r   <= in_tdata[15:0];
      arg_r      <= in_tdata[47:16];
      prio_r     <= in_tdata[55:48];
      scan_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    rd_idx_r <= scan_idx_r;
  end

  // Scan: first free slot, and the busy slot with the highest level
  // where the lowest index wins ties.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!rd_busy && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (rd_busy && (!best_found_r || rd_data.level > best_r.level)) begin
        best_found_r <= 1'b1;
        best_idx_r   <= rd_idx_r;
        best_r       <= rd_data;
      end
    end
  end

  // A dispatched task's priority becomes the running level it reports.
  a_dispatch_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r == ST_DISPATCHED)
      |-> (out_tdata_r[70:62] == {1'b0, out_tdata_r[55:48]}))
    else $error("dispatched priority differs from running level");

  // The read stage only runs during a scan.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("slot read data arrived outside a scan");

  // Nothing commits without a scan having finished or a finish item.
  a_commit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !rd_vld_r)
    else $error("commit while slot reads still in flight");

endmodule

// ===== rtl/core/pts_slot_mem.sv =====
// Slot table: task data in a synchronous memory plus per-slot busy flags.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_slot_mem
  import pts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SLOT_IW-1:0] rd_idx_i,
  output slot_data_t         rd_data_o,
  output logic               rd_busy_o,
  input  slot_wr_t           wr_i
);

  slot_data_t mem_r [SLOTS];
  logic [SLOTS-1:0] busy_r;

  // Task data: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_i.wr_en) begin
      mem_r[wr_i.idx] <= wr_i.data;
    end
    rd_data_o <= mem_r[rd_idx_i];
  end

  // Busy flags are cleared at reset so that every slot starts free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= '0;
      rd_busy_o <= 1'b0;
    end else begin
      rd_busy_o <= busy_r[rd_idx_i];
      if (wr_i.wr_en) begin
        busy_r[wr_i.idx] <= 1'b1;
      end else if (wr_i.clr_en) begin
        busy_r[wr_i.idx] <= 1'b0;
      end
    end
  end

  // A new task only goes into a free slot, and only a busy slot is freed.
  a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_i.wr_en |-> !busy_r[wr_i.idx])
    else $error("task written into a busy slot");

  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_i.clr_en |-> busy_r[wr_i.idx])
    else $error("free slot released again");

endmodule

// ===== rtl/core/pts_nest_stack.sv =====
// Running priority and the stack of preempted priorities.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_nest_stack
  import pts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  nest_ctrl_t                ctrl_i,
  output logic signed [LEVEL_W-1:0] running_o,
  output logic signed [LEVEL_W-1:0] top_o,
  output logic                      empty_o,
  output logic                      full_o
);

  logic signed [LEVEL_W-1:0] stack_r [NEST_DEPTH];
  logic signed [LEVEL_W-1:0] running_r;
  logic [NEST_CW-1:0]        count_r;
  logic [NEST_IW-1:0]        top_idx;
  logic [NEST_IW-1:0]        push_idx;

  assign top_idx  = NEST_IW'(count_r - 1'b1);
  assign push_idx = NEST_IW'(count_r);

  assign running_o = running_r;
  assign top_o     = stack_r[top_idx];
  assign empty_o   = (count_r == '0);
  assign full_o    = (count_r == NEST_CW'(NEST_DEPTH));

  // Saved levels hold data only below the fill count.
  always_ff @(posedge clk) begin
    if (ctrl_i.push) begin
      stack_r[push_idx] <= running_r;
    end
  end

  // Fill count and running level; idle is minus one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= -9'sd1;
      count_r   <= '0;
    end else if (ctrl_i.push) begin
      running_r <= ctrl_i.push_level;
      count_r   <= count_r + 1'b1;
    end else if (ctrl_i.pop) begin
      running_r <= stack_r[top_idx];
      count_r   <= count_r - 1'b1;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.push |-> !full_o)
    else $error("push onto a full nesting stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.pop |-> !empty_o && !ctrl_i.push)
    else $error("pop from an empty stack or together with a push");

endmodule

// ===== test/priority_task_slot_scheduler_test.sv =====
// Self-checking testbench for the priority task slot scheduler.
// Drives add, dispatch and finish events and checks every result against its model or the table.
// Depends on pts_pkg and priority_task_slot_scheduler.
`timescale 1ns / 1ps

module priority_task_slot_scheduler_test;
  import pts_pkg::*;

  // Kind code with no meaning: the block takes it and drops it.
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  localparam int EVENT_TARGET = 1950;
  localparam int MAX_GAP      = 12;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = SLOTS + 16;
  localparam int PRINT_CAP    = 40;

  typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN, MODE_NEST} burst_mode_t;

  // One result transaction as the scheduler should produce it.
  typedef struct packed {
    status_t                   status;
    logic [HANDLE_W-1:0]       handle;
    logic [ARG_W-1:0]          arg;
    logic [PRIO_W-1:0]         prio;
    logic [OUT_SLOT_W-1:0]     slot;
    logic signed [LEVEL_W-1:0] level;
  } sched_result_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    arg;
    logic [PRIO_W-1:0]   prio;
    int                  reps;
    int                  step;
    bit                  then_dispatch;
    bit                  known;
    sched_result_t       want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // Scheduler model state.
  bit                  tbl_busy   [SLOTS];
  logic [HANDLE_W-1:0] tbl_handle [SLOTS];
  logic [ARG_W-1:0]    tbl_arg    [SLOTS];
  logic [PRIO_W-1:0]   tbl_prio   [SLOTS];
  int                  level_stack [NEST_DEPTH];
  int                  cur_level = -1;
  int                  depth = 0;

  plan_row_t     plan [$];
  sched_result_t expected_results [$];

  int accepted_items = 0;
  int events_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int status_seen [8];
  int idle_cycles = 0;
  bit in_calm = 1'b0;

  priority_task_slot_scheduler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one event to the model and returns the result it causes, if any.
  task automatic sched_step(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] h,
                            input logic [ARG_W-1:0] a, input logic [PRIO_W-1:0] p,
                            output bit has_result, output sched_result_t res);
    int pick;
    int i;
    res = '0;
    has_result = 1'b1;
    pick = -1;
    case (kind)
      KIND_ADD: begin
        for (i = 0; i < SLOTS && pick < 0; i++)
          if (!tbl_busy[i]) pick = i;
        if (pick < 0) begin
          res.status = ST_FULL;
        end else begin
          tbl_busy[pick]   = 1'b1;
          tbl_handle[pick] = h;
          tbl_arg[pick]    = a;
          tbl_prio[pick]   = p;
          res.status = ST_ADDED;
          res.slot   = OUT_SLOT_W'(pick);
        end
      end
      KIND_DISPATCH: begin
        // Highest priority wins; a strict compare keeps the lowest index on ties.
        for (i = 0; i < SLOTS; i++)
          if (tbl_busy[i] && (pick < 0 || tbl_prio[i] > tbl_prio[pick])) pick = i;
        if (pick < 0 || int'(tbl_prio[pick]) <= cur_level) begin
          res.status = ST_NONE;
        end else if (depth >= NEST_DEPTH) begin
          res.status = ST_NEST_FULL;
        end else begin
          tbl_busy[pick] = 1'b0;
          level_stack[depth] = cur_level;
          depth++;
          cur_level  = int'(tbl_prio[pick]);
          res.status = ST_DISPATCHED;
          res.handle = tbl_handle[pick];
          res.arg    = tbl_arg[pick];
          res.prio   = tbl_prio[pick];
          res.slot   = OUT_SLOT_W'(pick);
        end
      end
      KIND_FINISH: begin
        if (depth == 0) begin
          res.status = ST_IDLE_FINISH;
        end else begin
          depth--;
          cur_level  = level_stack[depth];
          res.status = ST_FINISHED;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
    res.level = LEVEL_W'(cur_level);
  endtask

  // Sends one input transaction after a random gap and queues what it should cause.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] h,
                       input logic [ARG_W-1:0] a, input logic [PRIO_W-1:0] p,
                       input bit known, input sched_result_t want);
    int gap;
    bit has_result;
    sched_result_t res;
    if (accepted_items % 50 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {p, a, h};
    do @(posedge clk); while (in_tready !== 1'b1);
    accepted_items++;
    sched_step(kind, h, a, p, has_result, res);
    if (has_result) begin
      events_sent++;
      expected_results.push_back(known ? want : res);
    end
  endtask

  // Table row whose result comes from the model.
  task automatic plan_item(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] h,
                           input logic [ARG_W-1:0] a, input logic [PRIO_W-1:0] p,
                           input int reps, input int step, input bit then_dispatch);
    plan_row_t row;
    row.kind = kind;
    row.handle = h;
    row.arg = a;
    row.prio = p;
    row.reps = reps;
    row.step = step;
    row.then_dispatch = then_dispatch;
    row.known = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  // Table row with its result written out by hand.
  task automatic plan_known(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] h,
                            input logic [ARG_W-1:0] a, input logic [PRIO_W-1:0] p,
                            input status_t st, input logic [HANDLE_W-1:0] oh,
                            input logic [ARG_W-1:0] oa, input logic [PRIO_W-1:0] op,
                            input logic [OUT_SLOT_W-1:0] os, input int ol);
    plan_row_t row;
    row.kind = kind;
    row.handle = h;
    row.arg = a;
    row.prio = p;
    row.reps = 1;
    row.step = 0;
    row.then_dispatch = 1'b0;
    row.known = 1'b1;
    row.want.status = st;
    row.want.handle = oh;
    row.want.arg = oa;
    row.want.prio = op;
    row.want.slot = os;
    row.want.level = LEVEL_W'(ol);
    plan.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    // Keep the log short when the block is badly off; the count still grows.
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Stimulus: directed table, then random bursts, then wait for the last results.
  initial begin
    int k;
    int len;
    int roll;
    int pick;
    burst_mode_t mode;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] h;
    logic [ARG_W-1:0]    a;
    logic [PRIO_W-1:0]   p;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;

    // Empty table and idle level, then the field extremes.
    plan_known(KIND_FINISH, '0, '0, '0, ST_IDLE_FINISH, '0, '0, '0, '0, -1);
    plan_known(KIND_DISPATCH, '0, '0, '0, ST_NONE, '0, '0, '0, '0, -1);
    plan_item(KIND_NOP, 16'h5A5A, 32'h1234_5678, 8'h80, 1, 0, 1'b0);
    plan_known(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, ST_ADDED, '0, '0, '0, 6'd0, -1);
    plan_known(KIND_ADD, '0, '0, '0, ST_ADDED, '0, '0, '0, 6'd1, -1);
    plan_known(KIND_DISPATCH, '0, '0, '0, ST_DISPATCHED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF,
               6'd0, 255);
    // Priority zero is not above the running level.
    plan_known(KIND_DISPATCH, '0, '0, '0, ST_NONE, '0, '0, '0, '0, 255);
    plan_known(KIND_FINISH, '0, '0, '0, ST_FINISHED, '0, '0, '0, '0, -1);
    plan_known(KIND_DISPATCH, '0, '0, '0, ST_DISPATCHED, '0, '0, '0, 6'd1, 0);
    plan_known(KIND_FINISH, '0, '0, '0, ST_FINISHED, '0, '0, '0, '0, -1);
    // Fill every slot, then one add too many.
    plan_item(KIND_ADD, 16'h0100, 32'hA5A5_0000, 8'd0, SLOTS, 2, 1'b0);
    plan_known(KIND_ADD, 16'hBEEF, 32'hCAFE_F00D, 8'd7, ST_FULL, '0, '0, '0, '0, -1);
    // Nest up to the stack depth with ever more urgent tasks.
    plan_item(KIND_DISPATCH, '0, '0, '0, 1, 0, 1'b0);
    plan_item(KIND_ADD, 16'h0200, 32'h0F0F_0F0F, 8'd130, NEST_DEPTH - 1, 10, 1'b1);
    plan_item(KIND_ADD, 16'h0300, 32'h8000_0001, 8'd255, 1, 0, 1'b0);
    plan_known(KIND_DISPATCH, '0, '0, '0, ST_NEST_FULL, '0, '0, '0, '0, 190);
    // Unwind the whole stack and one finish beyond it.
    plan_item(KIND_FINISH, '0, '0, '0, NEST_DEPTH + 1, 0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (k = 0; k < plan[r].reps; k++) begin
        issue(plan[r].kind, plan[r].handle + HANDLE_W'(k), plan[r].arg + ARG_W'(k),
              plan[r].prio + PRIO_W'(k * plan[r].step), plan[r].known, plan[r].want);
        if (plan[r].then_dispatch) issue(KIND_DISPATCH, '0, '0, '0, 1'b0, '0);
      end
    end

    // Random bursts, each leaning toward filling, draining, nesting or a mix.
    while (accepted_items < EVENT_TARGET) begin
      mode = burst_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(4, 40);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_FILL: begin
            if (roll < 85) kind = KIND_ADD;
            else if (roll < 95) kind = KIND_DISPATCH;
            else kind = KIND_NOP;
          end
          MODE_DRAIN: begin
            if (roll < 50) kind = KIND_DISPATCH;
            else if (roll < 95) kind = KIND_FINISH;
            else kind = KIND_NOP;
          end
          MODE_NEST: begin
            // Add a more urgent task, then dispatch it; now and then break the pattern.
            if (roll < 10) kind = KIND_W'($urandom_range(0, 3));
            else if (k % 2 == 0) kind = KIND_ADD;
            else kind = KIND_DISPATCH;
          end
          default: begin
            if (roll < 35) kind = KIND_ADD;
            else if (roll < 65) kind = KIND_DISPATCH;
            else if (roll < 92) kind = KIND_FINISH;
            else kind = KIND_NOP;
          end
        endcase
        pick = $urandom_range(0, 4);
        if ((mode == MODE_NEST || pick >= 3) && cur_level < 255)
          p = PRIO_W'($urandom_range(cur_level + 1, 255));
        else if (pick == 1)
          p = PRIO_W'($urandom_range(0, 7));
        else if (pick == 2)
          p = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        else
          p = PRIO_W'($urandom_range(0, 255));
        h = HANDLE_W'($urandom);
        a = $urandom;
        if ($urandom_range(0, 9) == 0) begin
          h = ($urandom_range(0, 1) == 1) ? '1 : '0;
          a = ($urandom_range(0, 1) == 1) ? '1 : '0;
        end
        issue(kind, h, a, p, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Anything still coming out now has no expectation and is flagged.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d events, %0d results: added %0d, full %0d, dispatched %0d, none %0d",
             events_sent, results_seen, status_seen[ST_ADDED], status_seen[ST_FULL],
             status_seen[ST_DISPATCHED], status_seen[ST_NONE]);
    $display("finished %0d, finish while idle %0d, nesting full %0d; %0d mismatches",
             status_seen[ST_FINISHED], status_seen[ST_IDLE_FINISH],
             status_seen[ST_NEST_FULL], mismatch_count);
    if (mismatch_count == 0) begin
      $display("priority_task_slot_scheduler_test OK");
    end else begin
      $display("priority_task_slot_scheduler_test NOT OK");
    end
    $finish;
  end

  // Result side: random stalls with calm stretches between them.
  initial begin : result_sink
    int stall;
    int taken;
    bit out_calm;
    taken = 0;
    out_calm = 1'b0;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 50 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      taken++;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    sched_result_t w;
    if (rst_n === 1'b1 && $isunknown(out_tvalid)) begin
      report_mismatch("out_tvalid known", 0, 1);
    end else if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      results_seen++;
      if (!$isunknown(out_tuser)) status_seen[out_tuser]++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_tuser, -1);
      end else begin
        w = expected_results.pop_front();
        if (out_tuser !== w.status) report_mismatch("status", out_tuser, w.status);
        if (out_tdata[15:0] !== w.handle) report_mismatch("handle", out_tdata[15:0], w.handle);
        if (out_tdata[47:16] !== w.arg) report_mismatch("arg", out_tdata[47:16], w.arg);
        if (out_tdata[55:48] !== w.prio) report_mismatch("priority", out_tdata[55:48], w.prio);
        if (out_tdata[61:56] !== w.slot) report_mismatch("slot", out_tdata[61:56], w.slot);
        if (out_tdata[70:62] !== w.level)
          report_mismatch("running level", $signed(out_tdata[70:62]), w.level);
        if (out_tdata[71] !== 1'b0) report_mismatch("pad bit", out_tdata[71], 0);
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
      $display("priority_task_slot_scheduler_test NOT OK");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/pts_pkg.sv
rtl/core/pts_slot_mem.sv
rtl/core/pts_nest_stack.sv
rtl/core/priority_task_slot_scheduler.sv
test/priority_task_slot_scheduler_test.sv
